// ===== hw/rtl/sfae_pkg.sv =====
// Shared types and constants for the serial frame ack/echo engine.
// No dependencies; used by serial_frame_ack_echo_engine.
package sfae_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACK_RESERVE = 2'd0;
    localparam logic [1:0] CFG_MAX_ECHO    = 2'd1;
    localparam logic [1:0] CFG_ECHO_CODE   = 2'd2;

    // Configuration reset values
    localparam logic [9:0] RST_ACK_RESERVE = 10'd60;
    localparam logic [6:0] RST_MAX_ECHO    = 7'd124;
    localparam logic [7:0] RST_ECHO_CODE   = 8'd1;

    // Echo status codes
    typedef enum logic [1:0] {
        ECHO_NONE     = 2'd0,
        ECHO_QUEUED   = 2'd1,
        ECHO_TOO_LONG = 2'd2,
        ECHO_NO_SPACE = 2'd3
    } t_echo_status;

    // Fixed ack bytes after the id
    localparam logic [7:0] ACK_LEN_BYTE  = 8'd1;
    localparam logic [7:0] ACK_CODE_BYTE = 8'd0;
    localparam logic [7:0] ACK_BYTES     = 8'd3;
    // Echo header bytes, added to the payload length and ack reserve in the free-space check
    localparam logic [7:0] ECHO_OVERHEAD = 8'd4;

    // Receive parser phases
    typedef enum logic [1:0] {
        PH_ID      = 2'd0,
        PH_LEN     = 2'd1,
        PH_TYPE    = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_rx_phase;

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_POP    = 10'b00_0000_0010,
        S_POPD   = 10'b00_0000_0100,
        S_ACKCHK = 10'b00_0000_1000,
        S_ACK    = 10'b00_0001_0000,
        S_ECHK   = 10'b00_0010_0000,
        S_EHDR   = 10'b00_0100_0000,
        S_PRD    = 10'b00_1000_0000,
        S_PWR    = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    // Result item: tx_valid, tx_byte, frame_done, ack_queued, echo_status, queue_free
    typedef struct packed {
        logic [9:0]   queue_free;
        t_echo_status echo_status;
        logic         ack_queued;
        logic         frame_done;
        logic [7:0]   tx_byte;
        logic         tx_valid;
    } t_result;

endpackage

// ===== hw/rtl/serial_frame_ack_echo_engine.sv =====
// Frame receiver with ack/echo replies queued into a transmit ring.
// Depends on sfae_pkg (types, codes, constants).
//
// Each request passes through the sequencer: a header byte or a tick on an empty
// ring goes straight to the output state, a tick that pops passes the pop states,
// and a frame end runs the ack and echo checks, pushes and an echo copy of n payload
// bytes (one ring write per cycle, a payload read before each copy). One request at
// a time; ready again the cycle after the result is loaded; a held result stalls.
// Reset (synchronous, active low) clears pointers, parser and configuration;
// the ring and payload memories are not cleared.
module serial_frame_ack_echo_engine #(
    parameter int QUEUE_DEPTH   = 1024,
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request: tuser = kind; tdata = rx_byte
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,   // [0] kind
    // result
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] tx_valid, [8:1] tx_byte, [9] frame_done,
                                     // [10] ack_queued, [12:11] echo_status,
                                     // [22:13] queue_free, [23] zero
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = PW + 1;
    localparam int CW = (FW > 11) ? FW : 11;
    localparam int PI = $clog2(PAYLOAD_DEPTH);
    localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_F   = FW'(QUEUE_DEPTH);
    localparam logic [8:0]    PAYLOAD_N = 9'(PAYLOAD_DEPTH);

    sfae_pkg::t_state       r_state;
    sfae_pkg::t_rx_phase    r_phase;
    logic [PW-1:0]          r_rp;
    logic [PW-1:0]          r_wp;
    logic [7:0]             r_id;
    logic [7:0]             r_len;
    logic [7:0]             r_type;
    logic [7:0]             r_cnt;
    logic [1:0]             r_step;
    logic [6:0]             r_idx;
    logic [9:0]             r_ack_reserve;
    logic [6:0]             r_max_echo;
    logic [7:0]             r_echo_code;
    sfae_pkg::t_result      r_res;
    logic                   r_out_valid;
    logic [23:0]            r_out_data;
    logic [7:0]             r_q_rd;
    logic [7:0]             r_p_rd;

    logic [7:0] mem_q [QUEUE_DEPTH];
    logic [7:0] mem_p [PAYLOAD_DEPTH];

    logic [PW-1:0] w_rp_inc;
    logic [PW-1:0] w_wp_inc;
    logic [FW-1:0] w_free;
    logic          w_empty;
    logic          w_in_acc;
    logic          w_push;
    logic [7:0]    w_push_byte;
    logic [CW-1:0] w_need;
    logic          w_too_long;
    logic          w_no_space;
    logic          w_fin_pay;
    logic [7:0]    w_rx;
    sfae_pkg::t_result w_result;

    // Pointer advance with wrap at the ring depth
    assign w_rp_inc = (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
    assign w_wp_inc = (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);

    // Free space and emptiness of the ring
    always_comb begin
        if (r_rp > r_wp) begin
            w_free = FW'(r_rp) - FW'(r_wp) - FW'(1);
        end else begin
            w_free = FW'(r_rp) + DEPTH_F - FW'(r_wp) - FW'(1);
        end
    end
    assign w_empty = (w_rp_inc == r_wp);

    // Echo admission checks
    assign w_need     = CW'(r_ack_reserve) + CW'(r_len) + CW'(sfae_pkg::ECHO_OVERHEAD);
    assign w_too_long = (r_len > {1'b0, r_max_echo});
    assign w_no_space = (CW'(w_free) < w_need);

    assign o_s_tready = (r_state == sfae_pkg::S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_rx       = i_s_tdata;
    assign w_fin_pay  = ({1'b0, r_cnt} + 9'd1) >= {1'b0, r_len};

    // Ring write unit: one byte per cycle, chosen by the sequencer
    always_comb begin
        w_push      = 1'b0;
        w_push_byte = r_p_rd;
        unique case (r_state)
            sfae_pkg::S_ACK: begin
                w_push = 1'b1;
                case (r_step)
                    2'd0:    w_push_byte = r_id;
                    2'd1:    w_push_byte = sfae_pkg::ACK_LEN_BYTE;
                    default: w_push_byte = sfae_pkg::ACK_CODE_BYTE;
                endcase
            end
            sfae_pkg::S_EHDR: begin
                w_push = 1'b1;
                case (r_step)
                    2'd0:    w_push_byte = r_id;
                    2'd1:    w_push_byte = r_len + 8'd2;
                    2'd2:    w_push_byte = r_len + 8'd1;
                    default: w_push_byte = r_type;
                endcase
            end
            sfae_pkg::S_PWR: begin
                w_push = 1'b1;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    // Ring memory: one write port, registered read at the next pop slot
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            mem_q[r_wp] <= w_push_byte;
        end
        r_q_rd <= mem_q[w_rp_inc];
    end

    // Payload memory: written while receiving, read back during echo copy
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !i_s_tuser[0] && (r_phase == sfae_pkg::PH_PAYLOAD)
                && ({1'b0, r_cnt} < PAYLOAD_N)) begin
            mem_p[r_cnt[PI-1:0]] <= w_rx;
        end
        r_p_rd <= mem_p[PI'(r_idx)];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_reserve <= sfae_pkg::RST_ACK_RESERVE;
            r_max_echo    <= sfae_pkg::RST_MAX_ECHO;
            r_echo_code   <= sfae_pkg::RST_ECHO_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sfae_pkg::CFG_ACK_RESERVE: r_ack_reserve <= i_cfg_wdata;
                sfae_pkg::CFG_MAX_ECHO:    r_max_echo    <= i_cfg_wdata[6:0];
                sfae_pkg::CFG_ECHO_CODE:   r_echo_code   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Result packed with the free count seen after the step
    always_comb begin
        w_result            = r_res;
        w_result.queue_free = 10'(w_free);
    end

    // Sequencer: parse, push ack and echo, pop, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfae_pkg::S_IDLE;
            r_phase     <= sfae_pkg::PH_ID;
            r_rp        <= '0;
            r_wp        <= PW'(1);
            r_id        <= '0;
            r_len       <= '0;
            r_type      <= '0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken result unless a new one replaces it
            if (r_out_valid && i_m_tready && (r_state != sfae_pkg::S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (w_push) begin
                r_wp <= w_wp_inc;
            end
            unique case (r_state)
                sfae_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_res <= '0;
                        if (i_s_tuser[0]) begin
                            r_state <= w_empty ? sfae_pkg::S_OUT : sfae_pkg::S_POP;
                        end else begin
                            unique case (r_phase)
                                sfae_pkg::PH_ID: begin
                                    r_id    <= w_rx;
                                    r_phase <= sfae_pkg::PH_LEN;
                                    r_state <= sfae_pkg::S_OUT;
                                end
                                sfae_pkg::PH_LEN: begin
                                    r_len   <= (w_rx == 8'd0) ? 8'd0 : w_rx - 8'd1;
                                    r_phase <= sfae_pkg::PH_TYPE;
                                    r_state <= sfae_pkg::S_OUT;
                                end
                                sfae_pkg::PH_TYPE: begin
                                    r_type <= w_rx;
                                    r_cnt  <= '0;
                                    if (r_len == 8'd0) begin
                                        r_phase <= sfae_pkg::PH_ID;
                                        r_state <= sfae_pkg::S_ACKCHK;
                                    end else begin
                                        r_phase <= sfae_pkg::PH_PAYLOAD;
                                        r_state <= sfae_pkg::S_OUT;
                                    end
                                end
                                default: begin
                                    r_cnt <= r_cnt + 8'd1;
                                    if (w_fin_pay) begin
                                        r_phase <= sfae_pkg::PH_ID;
                                        r_state <= sfae_pkg::S_ACKCHK;
                                    end else begin
                                        r_state <= sfae_pkg::S_OUT;
                                    end
                                end
                            endcase
                        end
                    end
                end
                // advance the read pointer; the read register fetches the byte
                sfae_pkg::S_POP: begin
                    r_rp    <= w_rp_inc;
                    r_state <= sfae_pkg::S_POPD;
                end
                sfae_pkg::S_POPD: begin
                    r_res.tx_valid <= 1'b1;
                    r_res.tx_byte  <= r_q_rd;
                    r_state        <= sfae_pkg::S_OUT;
                end
                sfae_pkg::S_ACKCHK: begin
                    r_res.frame_done <= 1'b1;
                    r_step           <= '0;
                    if (w_free >= FW'(sfae_pkg::ACK_BYTES)) begin
                        r_res.ack_queued <= 1'b1;
                        r_state          <= sfae_pkg::S_ACK;
                    end else begin
                        r_state <= sfae_pkg::S_ECHK;
                    end
                end
                sfae_pkg::S_ACK: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        r_state <= sfae_pkg::S_ECHK;
                    end
                end
                sfae_pkg::S_ECHK: begin
                    r_step <= '0;
                    if (r_type == r_echo_code) begin
                        if (w_too_long) begin
                            r_res.echo_status <= sfae_pkg::ECHO_TOO_LONG;
                            r_state           <= sfae_pkg::S_OUT;
                        end else if (w_no_space) begin
                            r_res.echo_status <= sfae_pkg::ECHO_NO_SPACE;
                            r_state           <= sfae_pkg::S_OUT;
                        end else begin
                            r_res.echo_status <= sfae_pkg::ECHO_QUEUED;
                            r_state           <= sfae_pkg::S_EHDR;
                        end
                    end else begin
                        r_state <= sfae_pkg::S_OUT;
                    end
                end
                sfae_pkg::S_EHDR: begin
                    r_step <= r_step + 2'd1;
                    r_idx  <= '0;
                    if (r_step == 2'd3) begin
                        r_state <= (r_len == 8'd0) ? sfae_pkg::S_OUT : sfae_pkg::S_PRD;
                    end
                end
                // wait for the payload read register
                sfae_pkg::S_PRD: begin
                    r_state <= sfae_pkg::S_PWR;
                end
                sfae_pkg::S_PWR: begin
                    if ((8'(r_idx) + 8'd1) == r_len) begin
                        r_state <= sfae_pkg::S_OUT;
                    end else begin
                        r_idx   <= r_idx + 7'd1;
                        r_state <= sfae_pkg::S_PRD;
                    end
                end
                // hand the result to the output register once it is free
                sfae_pkg::S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_data  <= {1'b0, w_result};
                        r_out_valid <= 1'b1;
                        r_state     <= sfae_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= sfae_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // The ring never overfills: read and write pointers stay apart
    a_ring_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp != r_wp)
        else $error("ring write pointer ran into read pointer");

    // Echo copy never reads past the frame's payload
    a_copy_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfae_pkg::S_PWR) |-> ((8'(r_idx) < r_len) && (r_idx <= r_max_echo)))
        else $error("echo copy index beyond payload");

    // A popped byte and a finished frame never share a result
    a_pop_excl_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[9]))
        else $error("pop and frame end in one result");

    // Ack and echo flags only appear with a completed frame
    a_flags_need_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[9]) |-> (!o_m_tdata[10] && (o_m_tdata[12:11] == 2'd0)))
        else $error("ack or echo status without frame end");

    // Ring pushes happen only while a frame reply is being queued
    a_push_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> r_res.frame_done)
        else $error("ring write outside frame reply");

endmodule
